/* design/icwk_pkg.sv */
// ----------------------------------------------------------------------------
// icwk_pkg
// Shared types and constants for the iambic CW keyer: step and result
// payloads, configuration set and register map.
// ----------------------------------------------------------------------------
package icwk_pkg;

    localparam int DIT_LEN_W   = 11;
    localparam int DUR_W       = 13;
    localparam int ELAPSED_W   = 14;
    localparam int CODE_W      = 8;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CODE_W-1:0]    CODE_START      = 8'hFE;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX     = 14'h3FFF;
    localparam logic [DIT_LEN_W-1:0] DIT_LENGTH_INIT = 11'd100;

    // Register index, taken from paddr[2]
    localparam logic REG_DIT_LENGTH = 1'b0;
    localparam logic REG_IAMBIC_B   = 1'b1;

    typedef struct packed {
        logic tick;
        logic dit_pressed;
        logic dah_pressed;
    } keyer_in_t;

    typedef struct packed {
        logic              key_down;
        logic              char_valid;
        logic [CODE_W-1:0] char_code;
    } keyer_out_t;

    typedef struct packed {
        logic [DIT_LEN_W-1:0] dit_length_ms;
        logic                 iambic_b_mode;
    } keyer_cfg_t;

endpackage

/* design/icwk_core.sv */
// ----------------------------------------------------------------------------
// icwk_core
// Keyer state machine, paddle latches and element timer. Advances one step
// for every accepted request and presents the step's result combinationally.
// ----------------------------------------------------------------------------
module icwk_core
    import icwk_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  keyer_in_t  item,
    input  keyer_cfg_t cfg,
    output keyer_out_t result
);

    typedef enum logic [2:0] {
        PH_IDLE          = 3'd0,
        PH_CHK_DIT       = 3'd1,
        PH_CHK_DAH       = 3'd2,
        PH_KEYED_PREP    = 3'd3,
        PH_KEYED         = 3'd4,
        PH_INTER_ELEMENT = 3'd5,
        PH_PRE_IDLE      = 3'd6
    } phase_t;

    phase_t               phase_reg,      phase_next;
    logic                 dit_latch_reg,  dit_latch_next;
    logic                 dah_latch_reg,  dah_latch_next;
    logic                 dit_prog_reg,   dit_prog_next;
    logic [DUR_W-1:0]     timer_dur_reg,  timer_dur_next;
    logic [ELAPSED_W-1:0] elapsed_reg,    elapsed_next;
    logic [CODE_W-1:0]    char_shift_reg, char_shift_next;
    logic                 key_line_reg,   key_line_next;

    logic [DUR_W-1:0]     dur_dit;
    logic [DUR_W-1:0]     dur_gap;
    logic [DUR_W-1:0]     dur_dah;
    logic [ELAPSED_W-1:0] elapsed_now;
    logic                 timer_done;
    logic                 char_valid;

    assign dur_dit = {{(DUR_W-DIT_LEN_W){1'b0}}, cfg.dit_length_ms};
    assign dur_gap = {dur_dit[DUR_W-2:0], 1'b0};
    assign dur_dah = dur_gap + dur_dit;

    // Tick advances the timer before the phase is evaluated; saturate at max
    assign elapsed_now = (item.tick && (elapsed_reg != ELAPSED_MAX))
                       ? elapsed_reg + 1'b1 : elapsed_reg;
    assign timer_done  = elapsed_now > {1'b0, timer_dur_reg};

    always_comb
    begin
        phase_next      = phase_reg;
        dit_latch_next  = dit_latch_reg;
        dah_latch_next  = dah_latch_reg;
        dit_prog_next   = dit_prog_reg;
        timer_dur_next  = timer_dur_reg;
        elapsed_next    = elapsed_now;
        char_shift_next = char_shift_reg;
        key_line_next   = key_line_reg;
        char_valid      = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                dit_latch_next  = dit_latch_reg | item.dit_pressed;
                dah_latch_next  = dah_latch_reg | item.dah_pressed;
                char_shift_next = CODE_START;
                phase_next      = PH_CHK_DIT;
            end
            PH_CHK_DIT:
            begin
                if (dit_latch_reg)
                begin
                    dit_prog_next   = 1'b1;
                    timer_dur_next  = dur_dit;
                    elapsed_next    = '0;
                    char_shift_next = {char_shift_reg[CODE_W-2:0], 1'b0};
                    phase_next      = PH_KEYED_PREP;
                end
                else
                begin
                    phase_next = PH_CHK_DAH;
                end
            end
            PH_CHK_DAH:
            begin
                elapsed_next = '0;
                if (dah_latch_reg)
                begin
                    timer_dur_next  = dur_dah;
                    char_shift_next = {char_shift_reg[CODE_W-2:0], 1'b1};
                    phase_next      = PH_KEYED_PREP;
                end
                else
                begin
                    timer_dur_next = dur_gap;
                    phase_next     = PH_PRE_IDLE;
                end
            end
            PH_KEYED_PREP:
            begin
                key_line_next  = 1'b1;
                elapsed_next   = '0;
                dit_latch_next = 1'b0;
                dah_latch_next = 1'b0;
                phase_next     = PH_KEYED;
            end
            PH_KEYED:
            begin
                if (timer_done)
                begin
                    key_line_next  = 1'b0;
                    timer_dur_next = dur_dit;
                    elapsed_next   = '0;
                    phase_next     = PH_INTER_ELEMENT;
                end
                else if (cfg.iambic_b_mode)
                begin
                    dit_latch_next = dit_latch_reg | item.dit_pressed;
                    dah_latch_next = dah_latch_reg | item.dah_pressed;
                end
            end
            PH_INTER_ELEMENT:
            begin
                dit_latch_next = dit_latch_reg | item.dit_pressed;
                dah_latch_next = dah_latch_reg | item.dah_pressed;
                if (timer_done)
                begin
                    if (dit_prog_reg)
                    begin
                        dit_latch_next = 1'b0;
                        dit_prog_next  = 1'b0;
                        phase_next     = PH_CHK_DAH;
                    end
                    else
                    begin
                        dah_latch_next = 1'b0;
                        timer_dur_next = dur_gap;
                        elapsed_next   = '0;
                        phase_next     = PH_PRE_IDLE;
                    end
                end
            end
            PH_PRE_IDLE:
            begin
                if (item.dit_pressed || item.dah_pressed || dit_latch_reg || dah_latch_reg)
                begin
                    dit_latch_next = dit_latch_reg | item.dit_pressed;
                    dah_latch_next = dah_latch_reg | item.dah_pressed;
                    phase_next     = PH_CHK_DIT;
                end
                else if (timer_done)
                begin
                    char_valid = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_PRE_IDLE;
            end
        endcase
    end

    assign result.key_down   = key_line_next;
    assign result.char_valid = char_valid;
    assign result.char_code  = char_valid ? char_shift_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_PRE_IDLE;
            dit_latch_reg  <= 1'b0;
            dah_latch_reg  <= 1'b0;
            dit_prog_reg   <= 1'b0;
            timer_dur_reg  <= '0;
            elapsed_reg    <= '0;
            char_shift_reg <= '0;
            key_line_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            dit_latch_reg  <= dit_latch_next;
            dah_latch_reg  <= dah_latch_next;
            dit_prog_reg   <= dit_prog_next;
            timer_dur_reg  <= timer_dur_next;
            elapsed_reg    <= elapsed_next;
            char_shift_reg <= char_shift_next;
            key_line_reg   <= key_line_next;
        end
    end

    // Key line is asserted exactly while an element is being sent
    a_key_matches_phase: assert property (@(posedge clk) disable iff (!rst_n)
        key_line_reg == (phase_reg == PH_KEYED))
        else $error("key line out of step with keyed phase");

    a_char_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && char_valid |=> phase_reg == PH_IDLE)
        else $error("character report not followed by idle");

    a_prep_keys: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == PH_KEYED_PREP |=> key_line_reg && !dit_latch_reg
                                               && !dah_latch_reg && elapsed_reg == '0)
        else $error("keyed preparation did not key and clear latches");

    a_dit_prog_code: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == PH_CHK_DIT && dit_latch_reg
            |=> dit_prog_reg && !char_shift_reg[0])
        else $error("dit start did not mark dit or shift in zero");

endmodule

/* design/iambic_cw_keyer_top.sv */
// ----------------------------------------------------------------------------
// iambic_cw_keyer_top
// Iambic A/B Morse keyer: one keyer step per input request, one result per
// step carrying the key line and any completed character code.
//
//   channel   dir   handshake                 payload
//   in        in    in_valid / in_ready       in_data  (keyer_in_t)
//   out       out   out_valid / out_ready     out_data (keyer_out_t)
//   config    in    psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One step per cycle while in_ready is high; result is out the cycle after.
// The step logic is a single pass from keyer state to the result register.
// in_ready stays high while the result register is empty or being drained.
// Reset puts the keyer in the character-gap phase with latches clear and
// loads dit length 100 ms, iambic A.
// ----------------------------------------------------------------------------
module iambic_cw_keyer_top
    import icwk_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  keyer_in_t             in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output keyer_out_t            out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    keyer_cfg_t cfg_reg;
    keyer_out_t result;
    keyer_out_t out_data_reg;
    logic       out_valid_reg;
    logic       step;
    logic       cfg_write;
    logic       reg_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_sel   = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dit_length_ms <= DIT_LENGTH_INIT;
            cfg_reg.iambic_b_mode <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_DIT_LENGTH: cfg_reg.dit_length_ms <= pwdata[DIT_LEN_W-1:0];
                REG_IAMBIC_B:   cfg_reg.iambic_b_mode <= pwdata[0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_DIT_LENGTH: prdata = {{(CFG_DATA_W-DIT_LEN_W){1'b0}}, cfg_reg.dit_length_ms};
            REG_IAMBIC_B:   prdata = {{(CFG_DATA_W-1){1'b0}}, cfg_reg.iambic_b_mode};
            default:        prdata = '0;
        endcase
    end

    // Take a new request whenever the result register is free or draining
    assign in_ready = !out_valid_reg || out_ready;
    assign step     = in_valid && in_ready;

    icwk_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_data),
        .cfg    (cfg_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_no_step_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !step)
        else $error("request taken while result register is blocked");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_data_reg))
        else $error("stalled result changed");

    a_step_fills: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("accepted request produced no result");

endmodule

/* sim/iambic_cw_keyer_top_tb.sv */
// ----------------------------------------------------------------------------
// iambic_cw_keyer_top_tb
// Self-checking bench for the iambic A/B keyer. Steps go in over a
// valid/ready channel with random idle bursts on both sides. A cycle-free
// model of the keyer predicts every result, and each returned result is
// checked field by field in order. Registers are written over the APB port
// between phases and read back.
// ----------------------------------------------------------------------------
module iambic_cw_keyer_top_tb;
    import icwk_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_CHECK_DIT = 3'd1,
        ST_CHECK_DAH = 3'd2,
        ST_KEY_PREP  = 3'd3,
        ST_KEYED     = 3'd4,
        ST_ELEM_GAP  = 3'd5,
        ST_CHAR_GAP  = 3'd6
    } keyer_phase_t;

    localparam int STEP_CAP = 20000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    keyer_in_t             in_data;
    logic                  out_valid;
    logic                  out_ready;
    keyer_out_t            out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Keyer model state, matching the reset values
    keyer_phase_t          m_phase      = ST_CHAR_GAP;
    logic                  m_dit_latch  = 1'b0;
    logic                  m_dah_latch  = 1'b0;
    logic                  m_dit_active = 1'b0;
    logic [DUR_W-1:0]      m_duration   = '0;
    logic [ELAPSED_W-1:0]  m_elapsed    = '0;
    logic [CODE_W-1:0]     m_code       = '0;
    logic                  m_key        = 1'b0;
    logic [DIT_LEN_W-1:0]  cfg_dit_len  = DIT_LENGTH_INIT;
    logic                  cfg_b_mode   = 1'b0;

    keyer_out_t            pending_results[$];
    keyer_out_t            last_due;
    keyer_out_t            result_want;
    int                    error_count = 0;
    bit                    calm = 1'b0;

    iambic_cw_keyer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #25_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic keyer_out_t advance_keyer(input keyer_in_t s);
        keyer_out_t       r;
        logic [DUR_W-1:0] unit;
        logic             expired;
        r       = '0;
        unit    = {{(DUR_W-DIT_LEN_W){1'b0}}, cfg_dit_len};
        if (s.tick && m_elapsed != ELAPSED_MAX)
            m_elapsed = m_elapsed + 1'b1;
        expired = m_elapsed > m_duration;
        case (m_phase)
            ST_IDLE:
            begin
                m_dit_latch |= s.dit_pressed;
                m_dah_latch |= s.dah_pressed;
                m_code       = CODE_START;
                m_phase      = ST_CHECK_DIT;
            end
            ST_CHECK_DIT:
            begin
                if (m_dit_latch)
                begin
                    m_dit_active = 1'b1;
                    m_duration   = unit;
                    m_elapsed    = '0;
                    m_code       = {m_code[CODE_W-2:0], 1'b0};
                    m_phase      = ST_KEY_PREP;
                end
                else
                    m_phase = ST_CHECK_DAH;
            end
            ST_CHECK_DAH:
            begin
                m_elapsed = '0;
                if (m_dah_latch)
                begin
                    m_duration = DUR_W'(unit * 3);
                    m_code     = {m_code[CODE_W-2:0], 1'b1};
                    m_phase    = ST_KEY_PREP;
                end
                else
                begin
                    m_duration = DUR_W'(unit * 2);
                    m_phase    = ST_CHAR_GAP;
                end
            end
            ST_KEY_PREP:
            begin
                m_key       = 1'b1;
                m_elapsed   = '0;
                m_dit_latch = 1'b0;
                m_dah_latch = 1'b0;
                m_phase     = ST_KEYED;
            end
            ST_KEYED:
            begin
                if (expired)
                begin
                    m_key      = 1'b0;
                    m_duration = unit;
                    m_elapsed  = '0;
                    m_phase    = ST_ELEM_GAP;
                end
                else if (cfg_b_mode)
                begin
                    m_dit_latch |= s.dit_pressed;
                    m_dah_latch |= s.dah_pressed;
                end
            end
            ST_ELEM_GAP:
            begin
                m_dit_latch |= s.dit_pressed;
                m_dah_latch |= s.dah_pressed;
                if (expired)
                begin
                    if (m_dit_active)
                    begin
                        m_dit_latch  = 1'b0;
                        m_dit_active = 1'b0;
                        m_phase      = ST_CHECK_DAH;
                    end
                    else
                    begin
                        m_dah_latch = 1'b0;
                        m_duration  = DUR_W'(unit * 2);
                        m_elapsed   = '0;
                        m_phase     = ST_CHAR_GAP;
                    end
                end
            end
            ST_CHAR_GAP:
            begin
                if (s.dit_pressed || s.dah_pressed || m_dit_latch || m_dah_latch)
                begin
                    m_dit_latch |= s.dit_pressed;
                    m_dah_latch |= s.dah_pressed;
                    m_phase      = ST_CHECK_DIT;
                end
                else if (expired)
                begin
                    r.char_valid = 1'b1;
                    r.char_code  = m_code;
                    m_phase      = ST_IDLE;
                end
            end
            default:
                m_phase = ST_CHAR_GAP;
        endcase
        r.key_down = m_key;
        return r;
    endfunction

    function automatic keyer_in_t make_step(input bit tick, input bit dit, input bit dah);
        keyer_in_t s;
        s.tick        = tick;
        s.dit_pressed = dit;
        s.dah_pressed = dah;
        return s;
    endfunction

    // Called right after a rising edge; returns at the edge that takes the request
    task automatic send_step(input keyer_in_t s);
        last_due = advance_keyer(s);
        pending_results.push_back(last_due);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Write one register, then read it back in the next transfer
    task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == REG_DIT_LENGTH)
            cfg_dit_len = value[DIT_LEN_W-1:0];
        else
            cfg_b_mode = value[0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == REG_DIT_LENGTH && prdata[DIT_LEN_W-1:0] !== cfg_dit_len)
            report_mismatch("dit_length_ms readback", prdata, cfg_dit_len);
        if (idx == REG_IAMBIC_B && prdata[0] !== cfg_b_mode)
            report_mismatch("iambic_b_mode readback", prdata, cfg_b_mode);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input int dit_len, input bit b_mode);
        wait_for_results();
        write_reg(REG_DIT_LENGTH, dit_len);
        write_reg(REG_IAMBIC_B, b_mode);
    endtask

    // Hold the paddles until the key goes down and a while longer, then release
    // until the character is reported
    task automatic key_char(input bit dit, input bit dah, input int extra);
        int steps;
        steps = 0;
        while (!m_key && steps < STEP_CAP)
        begin
            send_step(make_step(1'b1, dit, dah));
            steps++;
        end
        repeat (extra) send_step(make_step(1'b1, dit, dah));
        do
        begin
            send_step(make_step(1'b1, 1'b0, 1'b0));
            steps++;
        end
        while (!last_due.char_valid && steps < STEP_CAP);
    endtask

    task automatic test_first_gap();
        send_step(make_step(1'b0, 1'b0, 1'b0));
        send_step(make_step(1'b1, 1'b0, 1'b0));
        send_step(make_step(1'b0, 1'b0, 1'b0));
    endtask

    task automatic test_idle_repeat();
        set_config(1, 1'b0);
        repeat (12) send_step(make_step(1'b1, 1'b0, 1'b0));
    endtask

    task automatic test_single_elements();
        key_char(1'b1, 1'b0, 0);
        key_char(1'b0, 1'b1, 0);
    endtask

    task automatic test_squeeze();
        set_config(2, 1'b1);
        key_char(1'b1, 1'b1, 8);
        set_config(2, 1'b0);
        key_char(1'b1, 1'b1, 8);
        // more than seven elements push the oldest bits out of the code
        set_config(1, 1'b1);
        key_char(1'b1, 1'b1, 30);
    endtask

    task automatic test_zero_length();
        set_config(0, 1'b0);
        key_char(1'b1, 1'b0, 0);
        key_char(1'b0, 1'b1, 2);
    endtask

    task automatic test_length_change();
        set_config(4, 1'b0);
        while (!m_key)
            send_step(make_step(1'b1, 1'b0, 1'b1));
        repeat (2) send_step(make_step(1'b1, 1'b0, 1'b0));
        // running dah keeps its loaded duration; the space uses the new length
        set_config(2, 1'b0);
        key_char(1'b0, 1'b0, 0);
    endtask

    task automatic test_long_dah();
        set_config(20, 1'b0);
        key_char(1'b0, 1'b1, 0);
    endtask

    task automatic random_steps(input int count);
        int left;
        int pick;
        int len;
        bit dit;
        bit dah;
        left = count;
        while (left > 0)
        begin
            pick = $urandom_range(0, 9);
            dit  = (pick == 3 || pick == 4 || pick == 7 || pick == 8);
            dah  = (pick == 5 || pick == 6 || pick == 7 || pick == 8);
            len  = $urandom_range(1, 4 * cfg_dit_len + 4);
            repeat (len)
            begin
                if (pick == 9)
                    send_step(make_step($urandom_range(0, 1), $urandom_range(0, 1),
                                        $urandom_range(0, 1)));
                else
                    send_step(make_step($urandom_range(0, 9) != 0, dit, dah));
                left--;
            end
        end
    endtask

    task automatic test_random();
        int pick;
        int dit_len;
        for (int p = 0; p < 10; p++)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                dit_len = 0;
            else if (pick < 3)
                dit_len = pick;
            else
                dit_len = $urandom_range(3, 8);
            set_config(dit_len, $urandom_range(0, 1));
            calm = (p == 9);
            if (p == 4)
            begin
                random_steps(55);
                wait_for_results();
                random_steps(55);
            end
            else
                random_steps(110);
        end
    endtask

    initial
    begin
        out_ready <= 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 11) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with nothing pending", out_data, 0);
            else
            begin
                result_want = pending_results.pop_front();
                if (out_data.key_down !== result_want.key_down)
                    report_mismatch("key_down", out_data.key_down, result_want.key_down);
                if (out_data.char_valid !== result_want.char_valid)
                    report_mismatch("char_valid", out_data.char_valid, result_want.char_valid);
                if (out_data.char_code !== result_want.char_code)
                    report_mismatch("char_code", out_data.char_code, result_want.char_code);
            end
        end
    end

    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_first_gap();
        test_idle_repeat();
        test_single_elements();
        test_squeeze();
        test_zero_length();
        test_length_change();
        test_long_dah();
        test_random();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
